// File: rtl/assert_macros.svh
// Assertion helpers included by the port-level checker (spuv_checker).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication whose consequent is checked the cycle after the antecedent, masked during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Same-cycle implication, masked during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication that is also checked while reset is held.
`define ASSERT_RESET(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/spuv_pkg.sv
// ----------------------------------------------------------------------------
// spuv_pkg
// Shared types and constants of the spherical texel mapping pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spuv_pkg;

   // angle accumulator: 2^-32 turn units, signed, with headroom
   localparam int TURN_W     = 34;
   localparam int GUARD_BITS = 6;
   localparam int TABLE_LEN  = 24;
   localparam int KINV_W     = 30;
   localparam logic [KINV_W-1:0] KINV = 30'd652032874;
   localparam logic signed [TURN_W-1:0] HALF_TURN = 34'sh080000000;

   localparam logic [31:0] ATAN_TURN [TABLE_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // control that travels with every pipeline slot
   typedef struct packed {
      logic valid;
      logic zero;   // input vector was zero: angle and length forced to 0
   } ctl_type;

endpackage

// File: rtl/spuv_cordic_stage.sv
// ----------------------------------------------------------------------------
// spuv_cordic_stage
// One registered vectoring micro-rotation with a side-band payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spuv_cordic_stage #(
   parameter int XW     = 25,
   parameter int SIDE_W = 8,
   parameter int STEP   = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  spuv_pkg::ctl_type                 in_ctl,
   input  logic signed [XW-1:0]              in_x,
   input  logic signed [XW-1:0]              in_y,
   input  logic signed [spuv_pkg::TURN_W-1:0] in_z,
   input  logic [SIDE_W-1:0]                 in_side,
   output spuv_pkg::ctl_type                 out_ctl,
   output logic signed [XW-1:0]              out_x,
   output logic signed [XW-1:0]              out_y,
   output logic signed [spuv_pkg::TURN_W-1:0] out_z,
   output logic [SIDE_W-1:0]                 out_side
);

   localparam logic signed [spuv_pkg::TURN_W-1:0] STEP_ANGLE =
      spuv_pkg::TURN_W'(spuv_pkg::ATAN_TURN[STEP]);

   spuv_pkg::ctl_type                  ctl_ff;
   logic signed [XW-1:0]               x_ff, y_ff, x_in, y_in;
   logic signed [spuv_pkg::TURN_W-1:0] z_ff, z_in;
   logic [SIDE_W-1:0]                  side_ff;
   logic signed [XW-1:0]               xs, ys;

   always_comb begin
      xs = in_x >>> STEP;
      ys = in_y >>> STEP;
      // rotate toward the positive x axis
      if (!in_y[XW-1]) begin
         x_in = in_x + ys;
         y_in = in_y - xs;
         z_in = in_z + STEP_ANGLE;
      end else begin
         x_in = in_x - ys;
         y_in = in_y + xs;
         z_in = in_z - STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_ctl  = ctl_ff;
   assign out_x    = x_ff;
   assign out_y    = y_ff;
   assign out_z    = z_ff;
   assign out_side = side_ff;

endmodule

// File: rtl/spherical_uv_mapping_core.sv
// ----------------------------------------------------------------------------
// spherical_uv_mapping_core
// Equirectangular texel coordinate from a unit surface normal.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): normal x/y/z in signed Q1.NORMAL_FRAC_BITS, image
//   width and height in texels, and colour/bump presence flags. An item is
//   taken on a rising edge with req_valid high and req_stall low.
//   Response channel (rsp_*): texel column u, texel row v and the two fetch
//   flags, one response per request, in request order.
//   Throughput: one item per clock unless the output stalls. The pipeline is
//   two CORDIC passes of one micro-rotation stage per iteration, N being
//   ANGLE_ITERATIONS capped at 24, plus input, gain-correction multiply,
//   second-pass setup and output multiply stages.
//   The whole pipeline advances together; when the output holds an item and
//   rsp_stall is high, every stage holds and req_stall is raised the same
//   cycle, so nothing is dropped or repeated.
//   Reset clears all valid bits; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spherical_uv_mapping_core #(
   parameter int SIZE_BITS        = 13,
   parameter int NORMAL_FRAC_BITS = 15,
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [NORMAL_FRAC_BITS:0] req_normal_x,
   input  logic signed [NORMAL_FRAC_BITS:0] req_normal_y,
   input  logic signed [NORMAL_FRAC_BITS:0] req_normal_z,
   input  logic [SIZE_BITS:0]            req_img_width,
   input  logic [SIZE_BITS:0]            req_img_height,
   input  logic                          req_has_texture,
   input  logic                          req_has_bump,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [SIZE_BITS-1:0]          rsp_u_coord,
   output logic [SIZE_BITS-1:0]          rsp_v_coord,
   output logic                          rsp_fetch_color,
   output logic                          rsp_fetch_bump
);

   localparam int N    = (ANGLE_ITERATIONS < spuv_pkg::TABLE_LEN) ?
                         ANGLE_ITERATIONS : spuv_pkg::TABLE_LEN;
   localparam int NW   = NORMAL_FRAC_BITS + 1;
   localparam int XW   = NW + spuv_pkg::GUARD_BITS + 3;
   localparam int ZW   = spuv_pkg::TURN_W;
   localparam int SW   = SIZE_BITS + 1;
   localparam int PW   = XW + spuv_pkg::KINV_W;
   localparam int S1_W = NW + 2 * SW + 2;
   localparam int S2_W = ZW + 2 * SW + 2;
   localparam int DW   = ZW + 2;
   localparam int MW   = 16 + SW;

   function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] raw);
      logic [SW-1:0] s;
      s = raw;
      if (s == '0) s = SW'(1);
      if (s > (SW'(1) << SIZE_BITS)) s = SW'(1) << SIZE_BITS;
      return s;
   endfunction

   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // ---------------- pass 1 chain: atan2(nz, nx) and length ----------------
   spuv_pkg::ctl_type          c1 [0:N];
   logic signed [XW-1:0]       x1 [0:N];
   logic signed [XW-1:0]       y1 [0:N];
   logic signed [ZW-1:0]       z1 [0:N];
   logic [S1_W-1:0]            s1 [0:N];

   spuv_pkg::ctl_type          c0_ff, c0_in;
   logic signed [XW-1:0]       x0_ff, y0_ff, x0_in, y0_in, nx_g, nz_g;
   logic signed [ZW-1:0]       z0_ff, z0_in;
   logic [S1_W-1:0]            s0_ff;

   always_comb begin
      nx_g = XW'(req_normal_x) <<< spuv_pkg::GUARD_BITS;
      nz_g = XW'(req_normal_z) <<< spuv_pkg::GUARD_BITS;
      c0_in.valid = req_valid;
      c0_in.zero  = (nx_g == '0) && (nz_g == '0);
      x0_in = nx_g;
      y0_in = nz_g;
      z0_in = '0;
      // fold the left half plane onto the right
      if (nx_g[XW-1]) begin
         x0_in = -nx_g;
         y0_in = -nz_g;
         z0_in = nz_g[XW-1] ? -spuv_pkg::HALF_TURN : spuv_pkg::HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff <= '0;
      end else if (advance) begin
         c0_ff <= c0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x0_ff <= x0_in;
         y0_ff <= y0_in;
         z0_ff <= z0_in;
         s0_ff <= {req_normal_y, clamp_size(req_img_width), clamp_size(req_img_height),
                   req_has_texture, req_has_bump};
      end
   end

   assign c1[0] = c0_ff;
   assign x1[0] = x0_ff;
   assign y1[0] = y0_ff;
   assign z1[0] = z0_ff;
   assign s1[0] = s0_ff;

   for (genvar i = 0; i < N; i++) begin : g_pass1
      spuv_cordic_stage #(.XW(XW), .SIDE_W(S1_W), .STEP(i)) u_stage (
         .clock(clock), .reset(reset), .advance(advance),
         .in_ctl(c1[i]), .in_x(x1[i]), .in_y(y1[i]), .in_z(z1[i]), .in_side(s1[i]),
         .out_ctl(c1[i+1]), .out_x(x1[i+1]), .out_y(y1[i+1]), .out_z(z1[i+1]),
         .out_side(s1[i+1])
      );
   end

   // ---------------- gain correction: r = len * KINV >> 30 ----------------
   logic [PW-1:0]        prod;
   spuv_pkg::ctl_type    cm_ff;
   logic signed [XW-1:0] r_ff;
   logic signed [ZW-1:0] th1_ff;
   logic [S1_W-1:0]      sm_ff;

   assign prod = PW'(unsigned'(x1[N])) * PW'(spuv_pkg::KINV);

   always_ff @(posedge clock) begin
      if (reset) begin
         cm_ff <= '0;
      end else if (advance) begin
         cm_ff <= c1[N];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff   <= c1[N].zero ? '0 : signed'(prod[spuv_pkg::KINV_W +: XW]);
         th1_ff <= c1[N].zero ? '0 : z1[N];
         sm_ff  <= s1[N];
      end
   end

   // ---------------- pass 2 setup: vector (r, ny) ----------------
   spuv_pkg::ctl_type    c2 [0:N];
   logic signed [XW-1:0] x2 [0:N];
   logic signed [XW-1:0] y2 [0:N];
   logic signed [ZW-1:0] z2 [0:N];
   logic [S2_W-1:0]      s2 [0:N];

   spuv_pkg::ctl_type    cp_ff, cp_in;
   logic signed [XW-1:0] xp_ff, yp_ff, ny_g;
   logic [S2_W-1:0]      sp_ff;

   always_comb begin
      ny_g = XW'(signed'(sm_ff[S1_W-1 -: NW])) <<< spuv_pkg::GUARD_BITS;
      cp_in.valid = cm_ff.valid;
      cp_in.zero  = (r_ff == '0) && (ny_g == '0);
   end

   // r never goes negative, so no half-plane fold is needed here
   always_ff @(posedge clock) begin
      if (reset) begin
         cp_ff <= '0;
      end else if (advance) begin
         cp_ff <= cp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         xp_ff <= r_ff;
         yp_ff <= ny_g;
         sp_ff <= {th1_ff, sm_ff[2*SW+1:0]};
      end
   end

   assign c2[0] = cp_ff;
   assign x2[0] = xp_ff;
   assign y2[0] = yp_ff;
   assign z2[0] = '0;
   assign s2[0] = sp_ff;

   for (genvar i = 0; i < N; i++) begin : g_pass2
      spuv_cordic_stage #(.XW(XW), .SIDE_W(S2_W), .STEP(i)) u_stage (
         .clock(clock), .reset(reset), .advance(advance),
         .in_ctl(c2[i]), .in_x(x2[i]), .in_y(y2[i]), .in_z(z2[i]), .in_side(s2[i]),
         .out_ctl(c2[i+1]), .out_x(x2[i+1]), .out_y(y2[i+1]), .out_z(z2[i+1]),
         .out_side(s2[i+1])
      );
   end

   // ---------------- output: angles to texels ----------------
   logic signed [ZW-1:0] th1, th2, lon_full;
   logic signed [DW-1:0] d;
   logic [15:0]          lon16, lat16;
   logic [SW-1:0]        w, h;
   logic [MW-1:0]        u_prod, v_prod;
   logic                 valid_ff, color_ff, bump_ff;
   logic [SIZE_BITS-1:0] u_ff, v_ff;

   always_comb begin
      th1      = signed'(s2[N][S2_W-1 -: ZW]);
      th2      = c2[N].zero ? '0 : z2[N];
      w        = s2[N][2*SW+1 -: SW];
      h        = s2[N][SW+1 -: SW];
      lon_full = spuv_pkg::HALF_TURN - th1;
      lon16    = lon_full[31:16];
      d        = DW'(spuv_pkg::HALF_TURN) - (DW'(th2) <<< 1);
      // saturate latitude to [0, one turn)
      if (d[DW-1])             lat16 = '0;
      else if (d[DW-2:32] != '0) lat16 = '1;
      else                     lat16 = d[31:16];
      u_prod = MW'(lon16) * MW'(w);
      v_prod = MW'(lat16) * MW'(h);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= c2[N].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         u_ff     <= u_prod[16 +: SIZE_BITS];
         v_ff     <= v_prod[16 +: SIZE_BITS];
         color_ff <= s2[N][1];
         bump_ff  <= s2[N][0];
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_u_coord     = u_ff;
   assign rsp_v_coord     = v_ff;
   assign rsp_fetch_color = color_ff;
   assign rsp_fetch_bump  = bump_ff;

endmodule

// File: rtl/spuv_checker.sv
// ----------------------------------------------------------------------------
// spuv_checker
// Port-level checks of the spherical texel mapping core, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spuv_checker #(
   parameter int SIZE_BITS = 13
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [SIZE_BITS-1:0] rsp_u_coord,
   input logic [SIZE_BITS-1:0] rsp_v_coord,
   input logic                 rsp_fetch_color,
   input logic                 rsp_fetch_bump
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_u_coord) && $stable(rsp_v_coord) && $stable(rsp_fetch_color) && $stable(rsp_fetch_bump), "stalled response changed")
   `ASSERT_SAME(a_stall_only_backpressure, clock, reset, req_stall, rsp_valid && rsp_stall, "request stalled without output backpressure")
   `ASSERT_RESET(a_reset_empty, clock, reset, !rsp_valid, "response valid right after reset")

endmodule

bind spherical_uv_mapping_core spuv_checker #(.SIZE_BITS(SIZE_BITS)) u_spuv_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_u_coord(rsp_u_coord),
   .rsp_v_coord(rsp_v_coord),
   .rsp_fetch_color(rsp_fetch_color),
   .rsp_fetch_bump(rsp_fetch_bump)
);

// File: tb/sv/spherical_uv_mapping_checker.sv
// ----------------------------------------------------------------------------
// spherical_uv_mapping_checker
// Watches both channels of the texel mapping core, predicts the texel
// coordinate of every accepted item, and compares each response in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spherical_uv_mapping_checker #(
   parameter int SIZE_BITS        = 13,
   parameter int NORMAL_FRAC_BITS = 15,
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic signed [NORMAL_FRAC_BITS:0] req_normal_x,
   input  logic signed [NORMAL_FRAC_BITS:0] req_normal_y,
   input  logic signed [NORMAL_FRAC_BITS:0] req_normal_z,
   input  logic [SIZE_BITS:0]               req_img_width,
   input  logic [SIZE_BITS:0]               req_img_height,
   input  logic                             req_has_texture,
   input  logic                             req_has_bump,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [SIZE_BITS-1:0]             rsp_u_coord,
   input  logic [SIZE_BITS-1:0]             rsp_v_coord,
   input  logic                             rsp_fetch_color,
   input  logic                             rsp_fetch_bump,
   output int                               fail_count,
   output int                               texels_pending
);

   typedef struct {
      logic [SIZE_BITS-1:0] u;
      logic [SIZE_BITS-1:0] v;
      logic                 color;
      logic                 bump;
   } texel_type;

   localparam longint HALF = 64'sh80000000;

   texel_type texel_queue[$];

   // vectoring rotation: angle in 2^-32 turn units and gain-scaled length
   function automatic longint vector_angle(input longint xi, input longint yi,
                                           output longint len);
      longint x, y, z, xs, ys;
      x = xi;
      y = yi;
      z = 0;
      if (x == 0 && y == 0) begin
         len = 0;
         return 0;
      end
      if (x < 0) begin
         z = (y >= 0) ? HALF : -HALF;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < ANGLE_ITERATIONS && i < spuv_pkg::TABLE_LEN; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + longint'({32'd0, spuv_pkg::ATAN_TURN[i]});
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - longint'({32'd0, spuv_pkg::ATAN_TURN[i]});
         end
      end
      len = x;
      return z;
   endfunction

   function automatic longint unsigned size_limit(input logic [SIZE_BITS:0] raw);
      longint unsigned s;
      s = raw;
      if (s == 0) s = 1;
      if (s > (64'd1 << SIZE_BITS)) s = 64'd1 << SIZE_BITS;
      return s;
   endfunction

   function automatic texel_type map_texel(input logic signed [NORMAL_FRAC_BITS:0] nx,
                                           input logic signed [NORMAL_FRAC_BITS:0] ny,
                                           input logic signed [NORMAL_FRAC_BITS:0] nz,
                                           input logic [SIZE_BITS:0] w,
                                           input logic [SIZE_BITS:0] h,
                                           input logic tex, input logic bmp);
      texel_type t;
      longint len1, len2, radius, theta1, theta2, d;
      longint unsigned prod, lon16, lat16;
      theta1 = vector_angle(longint'(nx) <<< spuv_pkg::GUARD_BITS,
                            longint'(nz) <<< spuv_pkg::GUARD_BITS, len1);
      prod   = longint'(len1) * longint'({34'd0, spuv_pkg::KINV});
      radius = longint'(prod >> spuv_pkg::KINV_W);
      theta2 = vector_angle(radius, longint'(ny) <<< spuv_pkg::GUARD_BITS, len2);
      lon16  = ((longint'(HALF) - theta1) & 64'hFFFF_FFFF) >> 16;
      d      = HALF - 2 * theta2;
      if (d < 0) d = 0;
      if (d > 64'sh0FFFF_FFFF) d = 64'sh0FFFF_FFFF;
      lat16  = longint'(d) >> 16;
      t.u     = SIZE_BITS'((lon16 * size_limit(w)) >> 16);
      t.v     = SIZE_BITS'((lat16 * size_limit(h)) >> 16);
      t.color = tex;
      t.bump  = bmp;
      return t;
   endfunction

   initial begin
      fail_count     = 0;
      texels_pending = 0;
   end

   always @(posedge clock) begin
      texel_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            texel_queue.push_back(map_texel(req_normal_x, req_normal_y, req_normal_z,
                                            req_img_width, req_img_height,
                                            req_has_texture, req_has_bump));
         if (rsp_valid && !rsp_stall) begin
            if (texel_queue.size() == 0) begin
               $display("%0t: response with nothing expected: u=%0d v=%0d",
                        $time, rsp_u_coord, rsp_v_coord);
               fail_count++;
            end else begin
               want = texel_queue.pop_front();
               if (rsp_u_coord !== want.u || rsp_v_coord !== want.v ||
                   rsp_fetch_color !== want.color || rsp_fetch_bump !== want.bump) begin
                  $display({"%0t: mismatch expected u=%0d v=%0d c=%0b b=%0b, ",
                            "actual u=%0d v=%0d c=%0b b=%0b"},
                           $time, want.u, want.v, want.color, want.bump,
                           rsp_u_coord, rsp_v_coord, rsp_fetch_color, rsp_fetch_bump);
                  fail_count++;
               end
            end
         end
         texels_pending = texel_queue.size();
      end
   end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives normals and texture sizes into the texel mapping core with random
// idling on both sides, a long response hold-off and a drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   localparam int SB = 13;
   localparam int NF = 15;
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [NF:0] req_normal_x = 0, req_normal_y = 0, req_normal_z = 0;
   logic [SB:0] req_img_width = 1, req_img_height = 1;
   logic req_has_texture = 0, req_has_bump = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [SB-1:0] rsp_u_coord, rsp_v_coord;
   logic rsp_fetch_color, rsp_fetch_bump;

   int  fail_count, texels_pending;
   bit  quiet = 0;
   bit  long_hold = 0;
   int  idle_cycles = 0;

   always #5 clock = ~clock;

   spherical_uv_mapping_core u_dut (.*);

   spherical_uv_mapping_checker u_checker (.*);

   task automatic send_normal(input int nx, input int ny, input int nz,
                              input int w, input int h, input bit tex, input bit bmp);
      int gap;
      req_normal_x = nx[NF:0];
      req_normal_y = ny[NF:0];
      req_normal_z = nz[NF:0];
      req_img_width = w[SB:0];
      req_img_height = h[SB:0];
      req_has_texture = tex;
      req_has_bump = bmp;
      req_valid = 1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (!quiet && !long_hold && $urandom_range(9) < 3) begin
         gap = $urandom_range(13, 1);
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic int rand_size();
      case ($urandom_range(9))
         0: return $urandom_range(16383);
         1: return $urandom_range(16, 1);
         2: return 8192;
         default: return $urandom_range(8192, 1);
      endcase
   endfunction

   function automatic int rand_comp();
      case ($urandom_range(9))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return $urandom_range(64) - 32;
         default: return $urandom_range(65535) - 32768;
      endcase
   endfunction

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall = 1;
            for (n = 0; n < 300; n++) @(negedge clock);
            long_hold = 0;
         end else if (quiet) begin
            rsp_stall = 0;
            @(negedge clock);
         end else begin
            rsp_stall = ($urandom_range(3) == 0);
            n = $urandom_range(13, 1);
            repeat (n) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (6) @(negedge clock);
      reset = 0;

      // axes, poles, seam, zero vector, size extremes, every flag pair
      send_normal(32767, 0, 0, 8192, 8192, 0, 0);
      send_normal(-32768, 0, 0, 8192, 8192, 1, 0);
      send_normal(0, 0, 32767, 640, 480, 0, 1);
      send_normal(0, 0, -32768, 640, 480, 1, 1);
      send_normal(0, -32768, 0, 1024, 512, 1, 1);
      send_normal(0, 32767, 0, 1024, 512, 0, 0);
      send_normal(0, -32768, 0, 8192, 8192, 0, 1);
      send_normal(0, 0, 0, 8191, 8191, 1, 0);
      send_normal(0, 0, 0, 1, 1, 0, 0);
      send_normal(-32768, 0, -1, 4096, 2048, 1, 1);
      send_normal(-32768, 0, 1, 4096, 2048, 1, 1);
      send_normal(-32768, -32768, -32768, 8192, 8192, 1, 1);
      send_normal(32767, 32767, 32767, 8192, 8192, 1, 1);
      send_normal(1000, 2000, 3000, 300, 200, 0, 0);
      send_normal(23170, 0, 23170, 0, 0, 1, 0);
      send_normal(23170, 0, -23170, 16383, 16383, 0, 1);
      send_normal(-1, -1, -1, 8193, 9000, 1, 1);
      send_normal(1, 1, 1, 2, 3, 0, 0);
      send_normal(-11585, 28378, 11585, 10922, 5461, 1, 0);

      for (int i = 0; i < 850; i++) begin
         if (i == 300) long_hold = 1;
         if (i == 600) begin
            req_valid = 0;
            wait (texels_pending == 0);
            @(negedge clock);
         end
         if (i == 700) quiet = 1;
         send_normal(rand_comp(), rand_comp(), rand_comp(), rand_size(), rand_size(),
                     $urandom_range(1), $urandom_range(1));
      end
      req_valid = 0;

      wait (texels_pending == 0);
      repeat (60) @(negedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
